// ----- sv/vrs_pkg.sv -----
// Shared types and constants for the variable reference scanner.
package vrs_pkg;

   localparam int LINE_CHARS = 8192;
   localparam int IDX_W      = $clog2(LINE_CHARS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 2;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LINE_CHARS - 1);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(LINE_CHARS);

   // reset values of the meta characters
   localparam logic [CHAR_W-1:0] ESCAPE_RESET = 8'd92;
   localparam logic [CHAR_W-1:0] DOLLAR_RESET = 8'd36;
   localparam logic [CHAR_W-1:0] OPEN_RESET   = 8'd123;
   localparam logic [CHAR_W-1:0] CLOSE_RESET  = 8'd125;

   // fixed name characters besides letters and digits
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ESCAPE = 2'd0,
      CSR_DOLLAR = 2'd1,
      CSR_OPEN   = 2'd2,
      CSR_CLOSE  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      CL_EOL   = 3'd0,
      CL_ESC   = 3'd1,
      CL_DOL   = 3'd2,
      CL_OPEN  = 3'd3,
      CL_CLOSE = 3'd4,
      CL_ALPHA = 3'd5,
      CL_NAME  = 3'd6,
      CL_OTHER = 3'd7
   } char_class_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_SKIP     = 3'd1,
      PH_DOLLAR   = 3'd2,
      PH_BRACED   = 3'd3,
      PH_UNBRACED = 3'd4,
      PH_IGNORE   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_FOUND = 2'd1,
      EV_ERROR = 2'd2
   } event_type;

   typedef struct packed {
      logic [CHAR_W-1:0] escape_char;
      logic [CHAR_W-1:0] dollar_char;
      logic [CHAR_W-1:0] open_char;
      logic [CHAR_W-1:0] close_char;
   } meta_chars_type;

endpackage

// ----- sv/vrs_classify.sv -----
// Character classifier: end of line, meta characters, letters, name characters.
module vrs_classify
   import vrs_pkg::*;
(
   input  logic [CHAR_W-1:0] ch,
   input  meta_chars_type    meta,
   output char_class_type    cls
);

   logic is_alpha;
   logic is_name;

   assign is_alpha = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
   assign is_name  = (ch >= 8'h30 && ch <= 8'h39) || ch == CH_UNDERSCORE ||
                     ch == CH_COLON || ch == CH_MINUS;

   // first match wins; NUL is tested first so a zero register never matches
   always_comb begin
      priority if (ch == CH_NUL)           cls = CL_EOL;
      else if (ch == meta.escape_char)     cls = CL_ESC;
      else if (ch == meta.dollar_char)     cls = CL_DOL;
      else if (ch == meta.open_char)       cls = CL_OPEN;
      else if (ch == meta.close_char)      cls = CL_CLOSE;
      else if (is_alpha)                   cls = CL_ALPHA;
      else if (is_name)                    cls = CL_NAME;
      else                                 cls = CL_OTHER;
   end

endmodule

// ----- sv/variable_reference_scanner_core.sv -----
// Top level of the variable reference scanner: input stage, scan state, result register.
//
// Scans a text line one character per item (0 ends the line) and reports
// $name and ${name} references with the start and length of the whole
// reference and of the name, illegal characters inside braces, and the end
// of a line that holds no further reference. Escape, dollar and both brace
// characters are set through the csr_ port; write them only while no item
// is in flight. Throughput is one character per clock while req_stall is low:
// the scan state machine updates once per item. A result passes from the
// input register through the combinational scan step into the result
// register, which drives rsp_valid; a result is taken at an edge where
// rsp_stall is low. req_stall rises only when a character sits in the input
// register and the result register is full and stalled. Indexes saturate
// at LINE_CHARS-1 on very long lines, lengths at LINE_CHARS.
module variable_reference_scanner_core
   import vrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CHAR_W-1:0]    csr_data,
   // character input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CHAR_W-1:0]    req_ch,
   // result output
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_event_res,
   output logic [IDX_W-1:0]     rsp_ref_start,
   output logic [CNT_W-1:0]     rsp_ref_length,
   output logic [IDX_W-1:0]     rsp_name_start,
   output logic [IDX_W-1:0]     rsp_name_length,
   output logic                 rsp_line_end
);

   // configuration registers
   meta_chars_type meta_ff;

   // input stage
   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_ch_ff;

   // scan state
   phase_type         phase_ff,      phase_in;
   logic [IDX_W-1:0]  char_index_ff, char_index_in;
   logic [IDX_W-1:0]  ref_begin_ff,  ref_begin_in;
   logic [CNT_W-1:0]  ref_count_ff,  ref_count_in;
   logic [IDX_W-1:0]  name_begin_ff, name_begin_in;

   // result register
   logic              out_valid_ff;
   event_type         out_event_ff;
   logic [IDX_W-1:0]  out_ref_start_ff;
   logic [CNT_W-1:0]  out_ref_length_ff;
   logic [IDX_W-1:0]  out_name_start_ff;
   logic [IDX_W-1:0]  out_name_length_ff;
   logic              out_line_end_ff;

   // step results
   char_class_type    cls;
   logic              emit;
   event_type         ev;
   logic [IDX_W-1:0]  ev_ref_start;
   logic [CNT_W-1:0]  ev_ref_length;
   logic [IDX_W-1:0]  ev_name_start;
   logic [IDX_W-1:0]  ev_name_length;
   logic              ev_line_end;
   logic              new_line;

   logic              out_free;
   logic              process_en;
   logic [IDX_W-1:0]  idx_inc;
   logic [CNT_W-1:0]  cnt_inc;
   logic [CNT_W-1:0]  braced_len;
   logic [CNT_W-1:0]  unbraced_len;

   // ---------------- flow control ----------------
   // The result register frees up when empty or when its item is taken;
   // a character in the input register is processed exactly then.
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign process_en = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.escape_char <= ESCAPE_RESET;
         meta_ff.dollar_char <= DOLLAR_RESET;
         meta_ff.open_char   <= OPEN_RESET;
         meta_ff.close_char  <= CLOSE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ESCAPE: meta_ff.escape_char <= csr_data;
            CSR_DOLLAR: meta_ff.dollar_char <= csr_data;
            CSR_OPEN:   meta_ff.open_char   <= csr_data;
            CSR_CLOSE:  meta_ff.close_char  <= csr_data;
            default:    meta_ff             <= meta_ff;
         endcase
      end
   end

   // ---------------- input register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_ch_ff <= req_ch;
      end
   end

   vrs_classify u_classify (
      .ch   (in_ch_ff),
      .meta (meta_ff),
      .cls  (cls)
   );

   // ---------------- scan step ----------------
   assign idx_inc      = (char_index_ff < LAST_IDX) ? char_index_ff + 1'b1 : char_index_ff;
   assign cnt_inc      = (ref_count_ff < MAX_COUNT) ? ref_count_ff + 1'b1 : ref_count_ff;
   // name length: braces and dollar (3) off the count, dollar (1) when unbraced
   assign braced_len   = (cnt_inc >= CNT_W'(3)) ? cnt_inc - CNT_W'(3) : '0;
   assign unbraced_len = (ref_count_ff >= CNT_W'(1)) ? ref_count_ff - CNT_W'(1) : '0;

   always_comb begin
      phase_in       = phase_ff;
      ref_begin_in   = ref_begin_ff;
      ref_count_in   = ref_count_ff;
      name_begin_in  = name_begin_ff;
      emit           = 1'b0;
      ev             = EV_NONE;
      ev_ref_start   = '0;
      ev_ref_length  = '0;
      ev_name_start  = '0;
      ev_name_length = '0;
      ev_line_end    = 1'b0;
      new_line       = 1'b0;

      unique case (phase_ff)
         PH_IGNORE: begin
            // rest of the line after an error produces nothing
            if (cls == CL_EOL) begin
               new_line = 1'b1;
            end
         end
         PH_SKIP: begin
            if (cls == CL_EOL) begin
               emit        = 1'b1;
               ev_line_end = 1'b1;
               new_line    = 1'b1;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_DOLLAR: begin
            priority case (cls)
               CL_EOL: begin
                  emit        = 1'b1;
                  ev_line_end = 1'b1;
                  new_line    = 1'b1;
               end
               CL_OPEN: begin
                  phase_in      = PH_BRACED;
                  ref_count_in  = CNT_W'(2);
                  name_begin_in = idx_inc;
               end
               CL_ALPHA: begin
                  phase_in      = PH_UNBRACED;
                  ref_count_in  = CNT_W'(2);
                  name_begin_in = char_index_ff;
               end
               CL_ESC:  phase_in = PH_SKIP;
               default: phase_in = PH_IDLE;   // includes a second dollar
            endcase
         end
         PH_BRACED: begin
            if (cls == CL_ALPHA || cls == CL_NAME) begin
               ref_count_in = cnt_inc;
            end else if (cls == CL_CLOSE) begin
               ref_count_in   = cnt_inc;
               emit           = 1'b1;
               ev             = EV_FOUND;
               ev_ref_start   = ref_begin_ff;
               ev_ref_length  = cnt_inc;
               ev_name_start  = name_begin_ff;
               ev_name_length = braced_len[IDX_W-1:0];
               phase_in       = PH_IDLE;
            end else begin
               emit         = 1'b1;
               ev           = EV_ERROR;
               ev_ref_start = ref_begin_ff;
               ev_line_end  = 1'b1;
               if (cls == CL_EOL) begin
                  new_line = 1'b1;
               end else begin
                  phase_in = PH_IGNORE;
               end
            end
         end
         PH_UNBRACED: begin
            if (cls == CL_ALPHA || cls == CL_NAME) begin
               ref_count_in = cnt_inc;
            end else begin
               // terminator ends the name and is rescanned from idle
               emit           = 1'b1;
               ev             = EV_FOUND;
               ev_ref_start   = ref_begin_ff;
               ev_ref_length  = ref_count_ff;
               ev_name_start  = name_begin_ff;
               ev_name_length = unbraced_len[IDX_W-1:0];
               ev_line_end    = (cls == CL_EOL);
               priority case (cls)
                  CL_EOL: new_line = 1'b1;
                  CL_ESC: phase_in = PH_SKIP;
                  CL_DOL: begin
                     phase_in     = PH_DOLLAR;
                     ref_begin_in = char_index_ff;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
         default: begin   // idle
            priority case (cls)
               CL_EOL: begin
                  emit        = 1'b1;
                  ev_line_end = 1'b1;
                  new_line    = 1'b1;
               end
               CL_ESC: phase_in = PH_SKIP;
               CL_DOL: begin
                  phase_in     = PH_DOLLAR;
                  ref_begin_in = char_index_ff;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      endcase

      if (new_line) begin
         phase_in      = PH_IDLE;
         char_index_in = '0;
      end else begin
         char_index_in = idx_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         char_index_ff <= '0;
         ref_begin_ff  <= '0;
         ref_count_ff  <= '0;
         name_begin_ff <= '0;
      end else if (process_en) begin
         phase_ff      <= phase_in;
         char_index_ff <= char_index_in;
         ref_begin_ff  <= ref_begin_in;
         ref_count_ff  <= ref_count_in;
         name_begin_ff <= name_begin_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= process_en && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && process_en && emit) begin
         out_event_ff       <= ev;
         out_ref_start_ff   <= ev_ref_start;
         out_ref_length_ff  <= ev_ref_length;
         out_name_start_ff  <= ev_name_start;
         out_name_length_ff <= ev_name_length;
         out_line_end_ff    <= ev_line_end;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_res   = out_event_ff;
   assign rsp_ref_start   = out_ref_start_ff;
   assign rsp_ref_length  = out_ref_length_ff;
   assign rsp_name_start  = out_name_start_ff;
   assign rsp_name_length = out_name_length_ff;
   assign rsp_line_end    = out_line_end_ff;

   // ---------------- assertions ----------------
   // line-ending and error items always close the line
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_event_ff == EV_NONE || out_event_ff == EV_ERROR)
         |-> out_line_end_ff)
      else $error("end-of-line or error item without line_end");

   // a found name is always shorter than its whole reference
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_event_ff == EV_FOUND
         |-> ({1'b0, out_name_length_ff} < out_ref_length_ff))
      else $error("name length not below reference length");

   // end of line restarts the index and the scanner
   assert property (@(posedge clock) disable iff (reset)
      process_en && cls == CL_EOL
         |=> (char_index_ff == '0) && (phase_ff == PH_IDLE))
      else $error("end of line did not restart the scan");

endmodule

// ----- tb/reference_scan_checker.sv -----
// Scoreboard for the variable reference scanner: predicts the result of every character and checks it.
`timescale 1ns / 1ps
module reference_scan_checker
   import vrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CHAR_W-1:0]    csr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [CHAR_W-1:0]    req_ch,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [1:0]           rsp_event_res,
   input  logic [IDX_W-1:0]     rsp_ref_start,
   input  logic [CNT_W-1:0]     rsp_ref_length,
   input  logic [IDX_W-1:0]     rsp_name_start,
   input  logic [IDX_W-1:0]     rsp_name_length,
   input  logic                 rsp_line_end,
   output int                   fail_count,
   output int                   outstanding
);

   typedef struct packed {
      event_type        ev;
      logic [IDX_W-1:0] ref_start;
      logic [CNT_W-1:0] ref_length;
      logic [IDX_W-1:0] name_start;
      logic [IDX_W-1:0] name_length;
      logic             line_end;
   } scan_result_type;

   meta_chars_type    meta;
   phase_type         phase;
   logic [IDX_W-1:0]  char_idx;
   logic [IDX_W-1:0]  ref_begin;
   logic [IDX_W-1:0]  name_begin;
   logic [CNT_W-1:0]  ref_count;
   scan_result_type   expected_refs[$];
   int                reported = 0;

   function automatic char_class_type class_of(input logic [CHAR_W-1:0] c);
      if (c == CH_NUL) return CL_EOL;
      if (c == meta.escape_char) return CL_ESC;
      if (c == meta.dollar_char) return CL_DOL;
      if (c == meta.open_char) return CL_OPEN;
      if (c == meta.close_char) return CL_CLOSE;
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return CL_ALPHA;
      if ((c >= "0" && c <= "9") || c == CH_UNDERSCORE || c == CH_COLON || c == CH_MINUS)
         return CL_NAME;
      return CL_OTHER;
   endfunction

   function automatic scan_result_type make_result(input event_type ev,
                                                   input logic [IDX_W-1:0] rs,
                                                   input logic [CNT_W-1:0] rl,
                                                   input logic [IDX_W-1:0] ns,
                                                   input logic [IDX_W-1:0] nl,
                                                   input logic le);
      scan_result_type r;
      r.ev          = ev;
      r.ref_start   = rs;
      r.ref_length  = rl;
      r.name_start  = ns;
      r.name_length = nl;
      r.line_end    = le;
      return r;
   endfunction

   // idle handling, also used for the char that ends an unbraced name
   task automatic start_from_idle(input char_class_type cl);
      if (cl == CL_ESC) begin
         phase = PH_SKIP;
      end else if (cl == CL_DOL) begin
         phase     = PH_DOLLAR;
         ref_begin = char_idx;
      end else begin
         phase = PH_IDLE;
      end
   endtask

   task automatic scan_char(input logic [CHAR_W-1:0] c, output bit has_res,
                            output scan_result_type res);
      char_class_type cl;
      bit             line_done;
      cl        = class_of(c);
      has_res   = 1'b0;
      line_done = 1'b0;
      res       = '0;
      case (phase)
         PH_IGNORE: begin
            line_done = (cl == CL_EOL);
         end
         PH_SKIP: begin
            if (cl == CL_EOL) begin
               res       = make_result(EV_NONE, '0, '0, '0, '0, 1'b1);
               has_res   = 1'b1;
               line_done = 1'b1;
            end else begin
               phase = PH_IDLE;
            end
         end
         PH_DOLLAR: begin
            if (cl == CL_EOL) begin
               res       = make_result(EV_NONE, '0, '0, '0, '0, 1'b1);
               has_res   = 1'b1;
               line_done = 1'b1;
            end else if (cl == CL_OPEN) begin
               phase      = PH_BRACED;
               ref_count  = CNT_W'(2);
               name_begin = (char_idx != LAST_IDX) ? char_idx + 1'b1 : char_idx;
            end else if (cl == CL_ALPHA) begin
               phase      = PH_UNBRACED;
               ref_count  = CNT_W'(2);
               name_begin = char_idx;
            end else if (cl == CL_ESC) begin
               phase = PH_SKIP;
            end else begin
               phase = PH_IDLE;
            end
         end
         PH_BRACED: begin
            if (cl == CL_ALPHA || cl == CL_NAME) begin
               if (ref_count != MAX_COUNT) ref_count++;
            end else if (cl == CL_CLOSE) begin
               if (ref_count != MAX_COUNT) ref_count++;
               res = make_result(EV_FOUND, ref_begin, ref_count, name_begin,
                                 (ref_count >= 3) ? IDX_W'(ref_count - 3) : '0, 1'b0);
               has_res = 1'b1;
               phase   = PH_IDLE;
            end else begin
               res     = make_result(EV_ERROR, ref_begin, '0, '0, '0, 1'b1);
               has_res = 1'b1;
               if (cl == CL_EOL) line_done = 1'b1;
               else phase = PH_IGNORE;
            end
         end
         PH_UNBRACED: begin
            if (cl == CL_ALPHA || cl == CL_NAME) begin
               if (ref_count != MAX_COUNT) ref_count++;
            end else begin
               res = make_result(EV_FOUND, ref_begin, ref_count, name_begin,
                                 (ref_count >= 1) ? IDX_W'(ref_count - 1) : '0,
                                 cl == CL_EOL);
               has_res = 1'b1;
               if (cl == CL_EOL) line_done = 1'b1;
               else start_from_idle(cl);
            end
         end
         default: begin
            if (cl == CL_EOL) begin
               res       = make_result(EV_NONE, '0, '0, '0, '0, 1'b1);
               has_res   = 1'b1;
               line_done = 1'b1;
            end else begin
               start_from_idle(cl);
            end
         end
      endcase
      if (line_done) begin
         phase    = PH_IDLE;
         char_idx = '0;
      end else if (char_idx != LAST_IDX) begin
         char_idx++;
      end
   endtask

   always @(posedge clock) begin : watch
      scan_result_type want;
      bit              has_res;
      if (reset) begin
         meta       = {ESCAPE_RESET, DOLLAR_RESET, OPEN_RESET, CLOSE_RESET};
         phase      = PH_IDLE;
         char_idx   = '0;
         ref_begin  = '0;
         ref_count  = '0;
         name_begin = '0;
         expected_refs.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_ESCAPE: meta.escape_char = csr_data;
               CSR_DOLLAR: meta.dollar_char = csr_data;
               CSR_OPEN:   meta.open_char   = csr_data;
               CSR_CLOSE:  meta.close_char  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            scan_char(req_ch, has_res, want);
            if (has_res) expected_refs.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_refs.size() == 0) begin
               fail_count <= fail_count + 1;
               if (reported < 10) begin
                  reported++;
                  $display("%0t: unexpected result ev %0d rs %0d rl %0d ns %0d nl %0d end %0b",
                           $time, rsp_event_res, rsp_ref_start, rsp_ref_length,
                           rsp_name_start, rsp_name_length, rsp_line_end);
               end
            end else begin
               want = expected_refs.pop_front();
               if (rsp_event_res !== want.ev || rsp_ref_start !== want.ref_start ||
                   rsp_ref_length !== want.ref_length || rsp_name_start !== want.name_start ||
                   rsp_name_length !== want.name_length || rsp_line_end !== want.line_end)
               begin
                  fail_count <= fail_count + 1;
                  if (reported < 10) begin
                     reported++;
                     $display("%0t: mismatch ev %0d rs %0d rl %0d ns %0d nl %0d end %0b",
                              $time, rsp_event_res, rsp_ref_start, rsp_ref_length,
                              rsp_name_start, rsp_name_length, rsp_line_end);
                     $display("   expected ev %0d rs %0d rl %0d ns %0d nl %0d end %0b",
                              want.ev, want.ref_start, want.ref_length,
                              want.name_start, want.name_length, want.line_end);
                  end
               end
            end
         end
      end
      outstanding <= expected_refs.size();
   end

endmodule

// ----- tb/variable_reference_scanner_core_test.sv -----
// Top of the scanner testbench: clock, reset, stimulus, receiver and the final verdict.
`timescale 1ns / 1ps
module variable_reference_scanner_core_test;
   import vrs_pkg::*;

   logic                 clock;
   logic                 reset        = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [CHAR_W-1:0]    csr_data     = '0;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   logic [CHAR_W-1:0]    req_ch       = '0;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_event_res;
   logic [IDX_W-1:0]     rsp_ref_start;
   logic [CNT_W-1:0]     rsp_ref_length;
   logic [IDX_W-1:0]     rsp_name_start;
   logic [IDX_W-1:0]     rsp_name_length;
   logic                 rsp_line_end;

   // receiver stall: per-result wait plus one long hold-off to back the block up
   logic rx_wait = 1'b0;
   logic rx_hold = 1'b0;
   assign rsp_stall = rx_wait | rx_hold;

   int             fail_count;
   int             outstanding;
   int             chars_sent = 0;
   bit             tx_calm    = 1'b0;   // sender offers back to back
   bit             rx_calm    = 1'b0;   // receiver never stalls
   bit             hold_go    = 1'b0;
   // meta characters as last written, used to build well-formed references
   meta_chars_type cur_meta   = {ESCAPE_RESET, DOLLAR_RESET, OPEN_RESET, CLOSE_RESET};

   variable_reference_scanner_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_res   (rsp_event_res),
      .rsp_ref_start   (rsp_ref_start),
      .rsp_ref_length  (rsp_ref_length),
      .rsp_name_start  (rsp_name_start),
      .rsp_name_length (rsp_name_length),
      .rsp_line_end    (rsp_line_end)
   );

   reference_scan_checker scan_check (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_res   (rsp_event_res),
      .rsp_ref_start   (rsp_ref_start),
      .rsp_ref_length  (rsp_ref_length),
      .rsp_name_start  (rsp_name_start),
      .rsp_name_length (rsp_name_length),
      .rsp_line_end    (rsp_line_end),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs or drops a result
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // character sources
   // ---------------------------------------------------------------------
   function automatic logic [CHAR_W-1:0] rand_letter();
      if ($urandom_range(0, 1)) return CHAR_W'("a" + $urandom_range(0, 25));
      return CHAR_W'("A" + $urandom_range(0, 25));
   endfunction

   function automatic logic [CHAR_W-1:0] rand_name_char();
      case ($urandom_range(0, 5))
         0:       return CHAR_W'("0" + $urandom_range(0, 9));
         1:       return CH_UNDERSCORE;
         2:       return CH_COLON;
         3:       return CH_MINUS;
         default: return rand_letter();
      endcase
   endfunction

   // any byte but end of line
   function automatic logic [CHAR_W-1:0] rand_noise();
      return CHAR_W'($urandom_range(1, 255));
   endfunction

   // ---------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------
   // Called at a rising edge; returns at the edge where the item is taken.
   // valid stays high into the next call when no gap is drawn.
   task automatic send_char(input logic [CHAR_W-1:0] c);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_name(input int n);
      repeat (n) send_char(rand_name_char());
   endtask

   // drain: wait until nothing is expected, then let a character still in
   // the pipe that causes no result pass through
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // back-to-back writes of all four meta characters, block must be idle
   task automatic set_meta(input meta_chars_type m);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_ESCAPE;
      csr_data     <= m.escape_char;
      @(posedge clock);
      csr_index    <= CSR_DOLLAR;
      csr_data     <= m.dollar_char;
      @(posedge clock);
      csr_index    <= CSR_OPEN;
      csr_data     <= m.open_char;
      @(posedge clock);
      csr_index    <= CSR_CLOSE;
      csr_data     <= m.close_char;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_meta = m;
   endtask

   // A line of random tokens: mostly well-formed references with random
   // names, some escapes, broken braces and raw noise.
   task automatic send_random_line();
      int tokens;
      tokens  = $urandom_range(1, 6);
      tx_calm = ($urandom_range(0, 7) == 0);
      rx_calm = ($urandom_range(0, 7) == 0);
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin   // unbraced reference
               send_char(cur_meta.dollar_char);
               send_char(rand_letter());
               send_name($urandom_range(0, 5));
            end
            3, 4: begin      // braced reference, possibly empty
               send_char(cur_meta.dollar_char);
               send_char(cur_meta.open_char);
               send_name($urandom_range(0, 5));
               send_char(cur_meta.close_char);
            end
            5: begin         // escaped char
               send_char(cur_meta.escape_char);
               send_char($urandom_range(0, 1) ? cur_meta.dollar_char : rand_noise());
            end
            6: begin         // plain text
               repeat ($urandom_range(1, 3))
                  send_char($urandom_range(0, 1) ? rand_letter() : rand_noise());
            end
            7: begin         // braced name broken by a random char
               send_char(cur_meta.dollar_char);
               send_char(cur_meta.open_char);
               send_name($urandom_range(0, 3));
               send_char(rand_noise());
            end
            8: begin         // dollar followed by dollar or junk
               send_char(cur_meta.dollar_char);
               send_char($urandom_range(0, 1) ? cur_meta.dollar_char : rand_noise());
            end
            default: begin   // any byte, a zero ends the line early
               send_char(CHAR_W'($urandom_range(0, 255)));
            end
         endcase
      end
      send_char(CH_NUL);
   endtask

   // ---------------------------------------------------------------------
   // receiver side: random wait before each result
   // ---------------------------------------------------------------------
   initial begin : receiver
      int n;
      forever begin
         n = rx_calm ? 0 : $urandom_range(0, 6);
         if (n > 0) begin
            rx_wait <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rx_wait <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // long hold-off, counted here, while the sender keeps pushing
   initial begin : long_hold
      wait (hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (200) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      meta_chars_type m;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed lines with the reset meta characters
      send_text("$ab");               // name ended by end of line
      send_char(CH_NUL);
      send_text("${x}$$");            // braced name, then dollar after dollar
      send_char(CH_NUL);
      send_text("\\$a${");            // escaped dollar, then error at end of line
      send_char(CH_NUL);
      send_text("${-!}z");            // bad char in braces, rest ignored
      send_char(CH_NUL);
      send_text("\\");                // escape right before end of line
      send_char(CH_NUL);
      send_char(8'hFF);               // top-bit chars around a name ended by junk
      send_text("$Z");
      send_char(8'h80);
      send_char(CH_NUL);
      send_text("$");                 // lone dollar at end of line
      send_char(CH_NUL);

      // long line: index and count saturate; references at the last index
      send_char(cur_meta.dollar_char);
      send_char(cur_meta.open_char);
      repeat (LINE_CHARS + 100) send_char(rand_letter());
      send_char(cur_meta.close_char);
      send_text("${x}$ab");
      send_char(CH_NUL);

      // block fills and stalls its input during the long receiver hold
      tx_calm = 1'b1;
      rx_calm = 1'b1;
      hold_go = 1'b1;
      repeat (60) send_text("$a");
      send_char(CH_NUL);
      tx_calm = 1'b0;
      rx_calm = 1'b0;

      // random lines under several meta character settings
      for (int p = 0; p < 7; p++) begin
         wait_idle();
         case (p)
            0:       m = {ESCAPE_RESET, DOLLAR_RESET, OPEN_RESET, CLOSE_RESET};
            1:       m = {8'hFF, 8'hFE, 8'hFD, 8'hFC};
            2:       m = '0;                      // zero never matches
            3:       m = {"e", "d", "o", "c"};    // meta characters win over letters
            4:       m = {8'h01, "$", "$", "}"};  // dollar shadows open
            default: m = $urandom;
         endcase
         set_meta(m);
         chars_sent = 0;
         while (chars_sent < 180) send_random_line();
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
